/* rtl/core/machine_timer_with_trap_entry_defines.svh */
// assertion macros shared by the machine timer checker
// expects signals named clock and reset in the scope of use
`ifndef MACHINE_TIMER_WITH_TRAP_ENTRY_DEFINES_SVH
`define MACHINE_TIMER_WITH_TRAP_ENTRY_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define MTTE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define MTTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mtte_pkg.sv */
// types and constants for the machine timer with trap entry
// no dependencies
package mtte_pkg;

   localparam int unsigned XLEN = 64;
   localparam int unsigned TICK_W = 10;
   localparam int unsigned CSR_INDEX_W = 2;

   // action codes
   localparam logic [2:0] ACT_TICK       = 3'd0;
   localparam logic [2:0] ACT_WR_COMPARE = 3'd1;
   localparam logic [2:0] ACT_RD_TIME    = 3'd2;
   localparam logic [2:0] ACT_TRAP_CHECK = 3'd3;
   localparam logic [2:0] ACT_WR_ENABLE  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAP_VECTOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_IE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_SCALE  = 2'd2;

   localparam logic [TICK_W-1:0] TICK_SCALE_RESET = 10'd10;
   localparam logic [1:0]        MODE_MACHINE     = 2'b11;
   localparam logic [XLEN-1:0]   CAUSE_TIMER      = 64'h8000_0000_0000_0007;

   typedef struct packed {
      logic [2:0]      action;
      logic [XLEN-1:0] value;
      logic            ecall_flag;
   } req_type;

   typedef struct packed {
      logic [XLEN-1:0] result_value;
      logic            timer_pending;
      logic            trap_taken;
      logic            global_enable;
      logic            prior_enable;
      logic [1:0]      prior_mode;
      logic [XLEN-1:0] exception_pc;
      logic [XLEN-1:0] trap_cause;
   } rsp_type;

   typedef struct packed {
      logic [XLEN-1:0]   trap_vector;
      logic              timer_int_enable;
      logic [TICK_W-1:0] tick_scale;
   } cfg_type;

endpackage

/* rtl/core/mtte_core.sv */
// timer and trap-entry state with the per-beat update logic
// depends on mtte_pkg
module mtte_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  mtte_pkg::req_type item,
   input  mtte_pkg::cfg_type cfg,
   output mtte_pkg::rsp_type rsp
);
   import mtte_pkg::*;

   logic [XLEN-1:0] time_ff, time_in;
   logic [XLEN-1:0] compare_ff, compare_in;
   logic            pending_ff, pending_in;
   logic            enable_ff, enable_in;
   logic            prior_enable_ff, prior_enable_in;
   logic [1:0]      prior_mode_ff, prior_mode_in;
   logic [XLEN-1:0] epc_ff, epc_in;
   logic [XLEN-1:0] cause_ff, cause_in;
   logic [XLEN-1:0] result;
   logic            take;

   // trap decision uses the pending flag left by the previous beat
   assign take = enable_ff & pending_ff & cfg.timer_int_enable & ~item.ecall_flag;

   always_comb begin
      time_in         = time_ff;
      compare_in      = compare_ff;
      enable_in       = enable_ff;
      prior_enable_in = prior_enable_ff;
      prior_mode_in   = prior_mode_ff;
      epc_in          = epc_ff;
      cause_in        = cause_ff;
      result          = '0;
      case (item.action)
         ACT_TICK: begin
            time_in = time_ff + {{(XLEN-TICK_W){1'b0}}, cfg.tick_scale};
         end
         ACT_WR_COMPARE: begin
            compare_in = item.value;
         end
         ACT_RD_TIME: begin
            result = time_ff;
         end
         ACT_TRAP_CHECK: begin
            if (take) begin
               prior_enable_in = enable_ff;
               prior_mode_in   = MODE_MACHINE;
               enable_in       = 1'b0;
               epc_in          = item.value;
               cause_in        = CAUSE_TIMER;
               result          = cfg.trap_vector;
            end else begin
               result = item.value;
            end
         end
         ACT_WR_ENABLE: begin
            enable_in = item.value[0];
         end
         default: begin
         end
      endcase
      pending_in = (time_in >= compare_in);
   end

   always_comb begin
      rsp.result_value  = result;
      rsp.timer_pending = pending_in;
      rsp.trap_taken    = (item.action == ACT_TRAP_CHECK) & take;
      rsp.global_enable = enable_in;
      rsp.prior_enable  = prior_enable_in;
      rsp.prior_mode    = prior_mode_in;
      rsp.exception_pc  = epc_in;
      rsp.trap_cause    = cause_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff         <= '0;
         compare_ff      <= '0;
         pending_ff      <= 1'b0;
         enable_ff       <= 1'b0;
         prior_enable_ff <= 1'b0;
         prior_mode_ff   <= '0;
         epc_ff          <= '0;
         cause_ff        <= '0;
      end else if (fire) begin
         time_ff         <= time_in;
         compare_ff      <= compare_in;
         pending_ff      <= pending_in;
         enable_ff       <= enable_in;
         prior_enable_ff <= prior_enable_in;
         prior_mode_ff   <= prior_mode_in;
         epc_ff          <= epc_in;
         cause_ff        <= cause_in;
      end
   end

endmodule

/* rtl/core/machine_timer_with_trap_entry.sv */
// channel   | direction | handshake          | payload
// req_      | in        | req_valid/stall    | mtte_pkg::req_type (action, value, ecall_flag)
// rsp_      | out       | rsp_valid/stall    | mtte_pkg::rsp_type (one result per beat)
// csr_      | in        | csr_write_enable   | csr_index, csr_data (write only)
//
// one beat per cycle sustained while rsp_stall is low; a request beat is captured in the
// input register, worked on by mtte_core's add/compare and then lands in the result
// register, from which its result beat is offered on rsp_
// synchronous active-high reset clears the timer state and loads the register defaults
// rsp_stall holds the result register; the input register keeps taking a beat while
// the result register is empty or draining
// top level of the machine timer with trap entry; depends on mtte_pkg and mtte_core
module machine_timer_with_trap_entry (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mtte_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mtte_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [mtte_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mtte_pkg::XLEN-1:0]            csr_data
);
   import mtte_pkg::*;

   logic    in_vld_ff, in_vld_in;
   req_type in_item_ff;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff;
   rsp_type core_rsp;
   cfg_type cfg_ff;
   logic    advance;
   logic    req_fire;

   assign advance   = in_vld_ff & (~rsp_vld_ff | ~rsp_stall);
   assign req_stall = in_vld_ff & ~advance;
   assign req_fire  = req_valid & ~req_stall;
   assign in_vld_in = req_fire | (in_vld_ff & ~advance);
   assign rsp_vld_in = advance | (rsp_vld_ff & rsp_stall);

   mtte_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trap_vector      <= '0;
         cfg_ff.timer_int_enable <= 1'b0;
         cfg_ff.tick_scale       <= TICK_SCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TRAP_VECTOR: cfg_ff.trap_vector      <= csr_data;
            CSR_TIMER_IE:    cfg_ff.timer_int_enable <= csr_data[0];
            CSR_TICK_SCALE:  cfg_ff.tick_scale       <= csr_data[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/core/mtte_checker.sv */
// port-level checks for the machine timer with trap entry, bound to the top level
// depends on mtte_pkg and machine_timer_with_trap_entry_defines.svh
`include "machine_timer_with_trap_entry_defines.svh"

module mtte_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input mtte_pkg::rsp_type                rsp_payload
);
   import mtte_pkg::*;

   `MTTE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled rsp beat changed")

   // trap entry clears mie and always records machine mode
   `MTTE_ASSERT_NOW(a_trap_state, rsp_valid && rsp_payload.trap_taken, !rsp_payload.global_enable && rsp_payload.prior_enable && rsp_payload.prior_mode == MODE_MACHINE, "trap entry left wrong mstatus")

   `MTTE_ASSERT_NOW(a_cause_code, rsp_valid, rsp_payload.trap_cause == '0 || rsp_payload.trap_cause == CAUSE_TIMER, "unexpected trap cause")

   // a trap beat must show the cause it just wrote
   `MTTE_ASSERT_NOW(a_trap_cause, rsp_valid && rsp_payload.trap_taken, rsp_payload.trap_cause == CAUSE_TIMER, "trap beat without timer cause")

endmodule

bind machine_timer_with_trap_entry mtte_checker u_mtte_checker (.*);

/* bench/tb_machine_timer_with_trap_entry.sv */
`timescale 1ns / 100ps
// self-checking bench for machine_timer_with_trap_entry: directed and random beats
// checked against an in-bench timer and trap-entry predictor; depends on mtte_pkg and the rtl
module tb_machine_timer_with_trap_entry;
   import mtte_pkg::*;

   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 56;
   localparam int MAX_REPORTS   = 10;

   logic                   clock;
   logic                   reset;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [XLEN-1:0]        csr_data;

   // register mirror
   logic [XLEN-1:0]   cfg_vector;
   logic              cfg_mtie;
   logic [TICK_W-1:0] cfg_scale;

   // predicted timer and trap state
   logic [XLEN-1:0] time_now;
   logic [XLEN-1:0] time_cmp;
   logic            mtip;
   logic            mie_bit;
   logic            mpie_bit;
   logic [1:0]      mpp_bits;
   logic [XLEN-1:0] mepc_word;
   logic [XLEN-1:0] mcause_word;

   req_type         req_backlog[$];
   rsp_type         timer_rsp_q[$];
   int              send_idle_pct;
   int              stall_pct;
   int              mismatches = 0;
   int              idle_cycles = 0;
   bit              req_fire = 1'b0;
   logic [XLEN-1:0] gen_time;

   machine_timer_with_trap_entry dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   function automatic logic [XLEN-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // advances the predicted state by one request beat and returns the response it causes
   function automatic rsp_type step_timer(req_type r);
      rsp_type o;
      o = '0;
      case (r.action)
         ACT_TICK: begin
            time_now = time_now + cfg_scale;
         end
         ACT_WR_COMPARE: begin
            time_cmp = r.value;
         end
         ACT_RD_TIME: begin
            o.result_value = time_now;
         end
         ACT_TRAP_CHECK: begin
            // decision uses the pending flag left by the previous beat
            if (mie_bit && mtip && cfg_mtie && !r.ecall_flag) begin
               mpie_bit       = mie_bit;
               mpp_bits       = MODE_MACHINE;
               mie_bit        = 1'b0;
               mepc_word      = r.value;
               mcause_word    = CAUSE_TIMER;
               o.result_value = cfg_vector;
               o.trap_taken   = 1'b1;
            end else begin
               o.result_value = r.value;
            end
         end
         ACT_WR_ENABLE: begin
            mie_bit = r.value[0];
         end
         default: ;
      endcase
      mtip            = (time_now >= time_cmp);
      o.timer_pending = mtip;
      o.global_enable = mie_bit;
      o.prior_enable  = mpie_bit;
      o.prior_mode    = mpp_bits;
      o.exception_pc  = mepc_word;
      o.trap_cause    = mcause_word;
      return o;
   endfunction

   task automatic check_field(input string what, input logic [XLEN-1:0] want,
                              input logic [XLEN-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t %s mismatch: expected %h got %h", $time, what, want, got);
      end
   endtask

   task automatic add_req(input logic [2:0] act, input logic [XLEN-1:0] val, input logic ecall);
      req_type r;
      r.action     = act;
      r.value      = val;
      r.ecall_flag = ecall;
      req_backlog.push_back(r);
      if (act == ACT_TICK)
         gen_time = gen_time + cfg_scale;
   endtask

   task automatic drain();
      while (req_backlog.size() != 0 || req_valid || timer_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [XLEN-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_TRAP_VECTOR: cfg_vector = data;
         CSR_TIMER_IE:    cfg_mtie   = data[0];
         CSR_TICK_SCALE:  cfg_scale  = data[TICK_W-1:0];
         default: ;
      endcase
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // driver: a beat stays on the bus until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= req_backlog.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin : monitor
      rsp_type want;
      bit      rsp_fire;
      if (reset) begin
         req_fire    = 1'b0;
         idle_cycles = 0;
         time_now    = '0;
         time_cmp    = '0;
         mtip        = 1'b0;
         mie_bit     = 1'b0;
         mpie_bit    = 1'b0;
         mpp_bits    = '0;
         mepc_word   = '0;
         mcause_word = '0;
      end else begin
         req_fire = req_valid && !req_stall;
         rsp_fire = rsp_valid && !rsp_stall;
         if (req_fire)
            timer_rsp_q.push_back(step_timer(req_payload));
         if (rsp_fire) begin
            if (timer_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t response beat with nothing expected: %h", $time, rsp_payload);
            end else begin
               want = timer_rsp_q.pop_front();
               check_field("result_value", want.result_value, rsp_payload.result_value);
               check_field("timer_pending", XLEN'(want.timer_pending),
                           XLEN'(rsp_payload.timer_pending));
               check_field("trap_taken", XLEN'(want.trap_taken),
                           XLEN'(rsp_payload.trap_taken));
               check_field("global_enable", XLEN'(want.global_enable),
                           XLEN'(rsp_payload.global_enable));
               check_field("prior_enable", XLEN'(want.prior_enable),
                           XLEN'(rsp_payload.prior_enable));
               check_field("prior_mode", XLEN'(want.prior_mode),
                           XLEN'(rsp_payload.prior_mode));
               check_field("exception_pc", want.exception_pc, rsp_payload.exception_pc);
               check_field("trap_cause", want.trap_cause, rsp_payload.trap_cause);
            end
         end
         if (req_fire || rsp_fire)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int              p;
      int              n;
      int              sel;
      logic [2:0]      act;
      logic [XLEN-1:0] val;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_TRAP_VECTOR;
      csr_data         = '0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      cfg_vector       = '0;
      cfg_mtie         = 1'b0;
      cfg_scale        = TICK_SCALE_RESET;
      gen_time         = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: ecall is ignored outside trap checks, value by time reads, ticks and spare codes
      add_req(ACT_RD_TIME, '1, 1'b1);
      add_req(ACT_TICK, '1, 1'b1);
      add_req(ACT_TICK, '0, 1'b0);
      add_req(ACT_RD_TIME, '0, 1'b0);
      for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
         add_req(3'(a), '1, 1'b1);
      add_req(ACT_WR_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      add_req(ACT_WR_ENABLE, 64'h1, 1'b0);
      add_req(ACT_TRAP_CHECK, 64'h1234, 1'b0);   // pending but mtie clear
      add_req(ACT_WR_COMPARE, '1, 1'b0);
      add_req(ACT_TRAP_CHECK, '1, 1'b1);
      drain();

      write_csr(CSR_TRAP_VECTOR, '1);
      write_csr(CSR_TIMER_IE, 64'h1);
      write_csr(CSR_TICK_SCALE, 64'd1000);
      add_req(ACT_TRAP_CHECK, 64'h8000, 1'b0);   // compare at max, not pending
      add_req(ACT_WR_COMPARE, '0, 1'b1);
      add_req(ACT_TRAP_CHECK, 64'h4, 1'b1);      // ecall blocks the trap
      add_req(ACT_TRAP_CHECK, '1, 1'b0);         // trap entry
      add_req(ACT_TRAP_CHECK, 64'h10, 1'b0);     // enable cleared by the entry
      add_req(ACT_WR_ENABLE, '1, 1'b1);
      add_req(ACT_TICK, '0, 1'b0);
      add_req(ACT_RD_TIME, '0, 1'b0);
      add_req(ACT_TRAP_CHECK, '0, 1'b0);
      drain();

      // zero scale leaves time where it is
      write_csr(CSR_TICK_SCALE, 64'd0);
      add_req(ACT_TICK, '1, 1'b0);
      add_req(ACT_RD_TIME, '1, 1'b0);
      drain();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         write_csr(CSR_TRAP_VECTOR, (p == 0) ? '0 : (p == 1) ? '1 : rand64());
         write_csr(CSR_TIMER_IE, (p % 3 != 2) ? 64'h1 : 64'h0);
         write_csr(CSR_TICK_SCALE, (p % 4 == 0) ? 64'd1 : (p % 4 == 1) ? 64'd1000 :
                                   64'($urandom_range(1000, 1)));
         gen_time = time_now;
         n = 0;
         while (n < PHASE_ITEMS) begin
            if ($urandom_range(99) < 30) begin
               // trap entry sequence: enable, compare at or under time, tick, check
               add_req(ACT_WR_ENABLE, rand64() | 64'h1, 1'($urandom_range(1)));
               add_req(ACT_WR_COMPARE, gen_time - $urandom_range(2000),
                       1'($urandom_range(1)));
               add_req(ACT_TICK, rand64(), 1'($urandom_range(1)));
               add_req(ACT_TRAP_CHECK, rand64(), $urandom_range(9) == 0);
               n += 4;
            end else begin
               sel = $urandom_range(99);
               val = rand64();
               if (sel < 28)
                  act = ACT_TICK;
               else if (sel < 43)
                  act = ACT_WR_COMPARE;
               else if (sel < 55)
                  act = ACT_RD_TIME;
               else if (sel < 83)
                  act = ACT_TRAP_CHECK;
               else if (sel < 95)
                  act = ACT_WR_ENABLE;
               else
                  act = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
               if (act == ACT_WR_COMPARE) begin
                  case ($urandom_range(9))
                     0: ;
                     1: val = '0;
                     2: val = '1;
                     default: val = gen_time + $urandom_range(4000) - 64'd2000;
                  endcase
               end else if (act == ACT_WR_ENABLE) begin
                  val[0] = ($urandom_range(9) < 7);
               end
               add_req(act, val, 1'($urandom_range(1)));
               n++;
            end
         end
         drain();
      end

      if (mismatches == 0 && timer_rsp_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/mtte_pkg.sv
rtl/core/mtte_core.sv
rtl/core/machine_timer_with_trap_entry.sv
rtl/core/mtte_checker.sv
bench/tb_machine_timer_with_trap_entry.sv
